FILE: hw/rtl/mcg_pkg.sv
// ----------------------------------------------------------------------------
// mcg_pkg
// Shared constants and payload types of the mipmap chain generator.
// ----------------------------------------------------------------------------
package mcg_pkg;

  localparam int MAX_LOG2_SIZE   = 10;
  localparam int CHANNEL_BITS    = 16;

  localparam int PIX_BITS        = 16;
  localparam int LEVEL_BITS      = 4;
  localparam int POS_BITS        = 9;

  localparam int APB_DATA_BITS   = 32;
  localparam int APB_ADDR_BITS   = 3;
  localparam int LOG2_SIZE_RESET = 10;

  localparam logic REG_LOG2_SIZE = 1'b0;

  typedef struct packed {
    logic [PIX_BITS-1:0] red;
    logic [PIX_BITS-1:0] green;
    logic [PIX_BITS-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [LEVEL_BITS-1:0] level;
    logic [POS_BITS-1:0]   pos_x;
    logic [POS_BITS-1:0]   pos_y;
    logic [PIX_BITS-1:0]   avg_red;
    logic [PIX_BITS-1:0]   avg_green;
    logic [PIX_BITS-1:0]   avg_blue;
    logic                  last;
  } result_t;

endpackage

FILE: hw/rtl/mcg_cell.sv
// ----------------------------------------------------------------------------
// mcg_cell
// One level of the pyramid: position counters, held left pixel and pair-sum
// row memory of source level STAGE. Averages a 2x2 block and hands the new
// pixel to the next cell.
// ----------------------------------------------------------------------------
module mcg_cell #(
  parameter int MAX_LOG2 = mcg_pkg::MAX_LOG2_SIZE,
  parameter int CH_BITS  = mcg_pkg::CHANNEL_BITS,
  parameter int STAGE    = 0
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   clear,
  input  logic [3:0]             log2_size,
  input  logic                   up_valid,
  input  logic [3*CH_BITS-1:0]   up_pix,
  output logic                   dn_valid,
  output logic [3*CH_BITS-1:0]   dn_pix,
  input  logic                   next_emit,
  output logic                   emit_ready,
  output logic                   occupied,
  output logic                   res_valid,
  output mcg_pkg::result_t       res
);

  localparam int W     = MAX_LOG2 - STAGE;
  localparam int AW    = (W > 1) ? W - 1 : 1;
  localparam int DEPTH = 1 << AW;
  localparam int PW    = CH_BITS + 1;
  localparam int LB    = mcg_pkg::LEVEL_BITS;
  localparam int PB    = mcg_pkg::POS_BITS;
  localparam int OB    = mcg_pkg::PIX_BITS;
  localparam logic [W-1:0] ONES = '1;
  localparam bit HAS_NEXT = (STAGE + 1 < MAX_LOG2);

  logic                 tok_valid;
  logic [3*CH_BITS-1:0] tok_pix;
  logic [W-1:0]         col;
  logic [W-1:0]         row;
  logic [3*CH_BITS-1:0] held;
  logic [3*PW-1:0]      mem [DEPTH];
  logic [3*PW-1:0]      rd;

  logic                 active;
  logic                 next_active;
  logic [W-1:0]         side_m1;
  logic                 col_end;
  logic                 row_end;
  logic [AW-1:0]        addr;
  logic [3*PW-1:0]      pair;
  logic [3*CH_BITS-1:0] avg;

  always_comb begin
    active      = log2_size > 4'(STAGE);
    next_active = HAS_NEXT && (log2_size > 4'(STAGE + 1));
    side_m1     = ONES >> (4'(MAX_LOG2) - log2_size);
    col_end     = col == side_m1;
    row_end     = row == side_m1;
    addr        = AW'(col >> 1);
  end

  always_comb begin
    logic [PW:0] sum;
    sum  = '0;
    pair = '0;
    avg  = '0;
    for (int c = 0; c < 3; c++) begin
      pair[c*PW +: PW] = {1'b0, held[c*CH_BITS +: CH_BITS]} +
                         {1'b0, tok_pix[c*CH_BITS +: CH_BITS]};
      sum = {1'b0, rd[c*PW +: PW]} + {1'b0, pair[c*PW +: PW]};
      avg[c*CH_BITS +: CH_BITS] = sum[PW:2];
    end
  end

  always_comb begin
    emit_ready    = active & col[0] & row[0];
    occupied      = tok_valid;
    res_valid     = tok_valid & col[0] & row[0];
    dn_valid      = res_valid & next_active;
    dn_pix        = avg;
    res.level     = LB'(STAGE + 1);
    res.pos_x     = PB'(col >> 1);
    res.pos_y     = PB'(row >> 1);
    res.avg_red   = OB'(avg[0*CH_BITS +: CH_BITS]);
    res.avg_green = OB'(avg[1*CH_BITS +: CH_BITS]);
    res.avg_blue  = OB'(avg[2*CH_BITS +: CH_BITS]);
    res.last      = ~next_emit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_valid <= 1'b0;
    end else if (en) begin
      tok_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tok_pix <= up_pix;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      col <= '0;
      row <= '0;
    end else if (en && tok_valid) begin
      if (col_end) begin
        col <= '0;
        row <= row_end ? '0 : row + 1'b1;
      end else begin
        col <= col + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && tok_valid && !col[0]) begin
      held <= tok_pix;
    end
  end

  always_ff @(posedge clk) begin
    rd <= mem[addr];
    if (en && tok_valid && col[0] && !row[0]) begin
      mem[addr] <= pair;
    end
  end

endmodule

FILE: hw/rtl/mipmap_chain_generator_core.sv
// ----------------------------------------------------------------------------
// mipmap_chain_generator_core
// 2x2 box-filter mipmap pyramid of a square RGB texture, one cell per level.
// ----------------------------------------------------------------------------
// Usage:
//   Base pixels enter on the pixel channel in raster order; every lower level
//   leaves on the result channel tagged with level, position and a last flag
//   on the final result caused by one pixel. log2_size (APB, address 0) sets
//   the texture side; writing it restarts at pixel (0,0). Textures may be
//   streamed back to back.
//   Result path: the level-1 result passes the token register of the first cell
//   and then the result register; each further level adds its cell's register.
//   Throughput: a pixel walks the cell chain one cell per cycle while the
//   receiver does not stall, and the next pixel is taken once the chain is empty.
//   Reset: counters clear, log2_size returns to 10, no clearing pass needed.
//   Receiver stall: the result register holds and the whole chain freezes;
//   pixel_stall stays high until the chain drains.
// ----------------------------------------------------------------------------
module mipmap_chain_generator_core #(
  parameter int MAX_LOG2_SIZE = mcg_pkg::MAX_LOG2_SIZE,
  parameter int CHANNEL_BITS  = mcg_pkg::CHANNEL_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               pixel_valid,
  output logic                               pixel_stall,
  input  mcg_pkg::pixel_t                    pixel,
  output logic                               result_valid,
  input  logic                               result_stall,
  output mcg_pkg::result_t                   result,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [mcg_pkg::APB_ADDR_BITS-1:0]  paddr,
  input  logic [mcg_pkg::APB_DATA_BITS-1:0]  pwdata,
  output logic [mcg_pkg::APB_DATA_BITS-1:0]  prdata,
  output logic                               pready
);

  localparam int DW = mcg_pkg::APB_DATA_BITS;
  localparam logic [3:0] MAX_L = 4'(MAX_LOG2_SIZE);
  localparam logic [3:0] RESET_L = (mcg_pkg::LOG2_SIZE_RESET > MAX_LOG2_SIZE) ?
                                   4'(MAX_LOG2_SIZE) : 4'(mcg_pkg::LOG2_SIZE_RESET);

  logic [3:0]              log2_size;
  logic [3:0]              wr_value;
  logic                    cfg_write;
  logic                    en;
  logic                    busy;

  logic                    link_valid [MAX_LOG2_SIZE+1];
  logic [3*CHANNEL_BITS-1:0] link_pix [MAX_LOG2_SIZE+1];
  logic [MAX_LOG2_SIZE-1:0] emit;
  logic [MAX_LOG2_SIZE-1:0] occ;
  logic [MAX_LOG2_SIZE-1:0] res_valid;
  mcg_pkg::result_t        res [MAX_LOG2_SIZE];
  mcg_pkg::result_t        sel;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & (paddr[2] == mcg_pkg::REG_LOG2_SIZE);
  assign prdata    = (paddr[2] == mcg_pkg::REG_LOG2_SIZE) ? DW'(log2_size) : '0;

  always_comb begin
    wr_value = pwdata[3:0];
    if (wr_value == 4'd0) begin
      wr_value = 4'd1;
    end
    if (wr_value > MAX_L) begin
      wr_value = MAX_L;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      log2_size <= RESET_L;
    end else if (cfg_write) begin
      log2_size <= wr_value;
    end
  end

  assign busy        = |occ;
  assign en          = ~result_valid | ~result_stall;
  assign pixel_stall = busy | ~en;

  assign link_valid[0] = pixel_valid & ~pixel_stall;
  assign link_pix[0]   = {pixel.blue[CHANNEL_BITS-1:0], pixel.green[CHANNEL_BITS-1:0],
                          pixel.red[CHANNEL_BITS-1:0]};

  for (genvar i = 0; i < MAX_LOG2_SIZE; i++) begin : g_cell
    logic nxt_emit;
    if (i + 1 < MAX_LOG2_SIZE) begin : g_next
      assign nxt_emit = emit[i+1];
    end else begin : g_end
      assign nxt_emit = 1'b0;
    end

    mcg_cell #(
      .MAX_LOG2 (MAX_LOG2_SIZE),
      .CH_BITS  (CHANNEL_BITS),
      .STAGE    (i)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .en         (en),
      .clear      (cfg_write),
      .log2_size  (log2_size),
      .up_valid   (link_valid[i]),
      .up_pix     (link_pix[i]),
      .dn_valid   (link_valid[i+1]),
      .dn_pix     (link_pix[i+1]),
      .next_emit  (nxt_emit),
      .emit_ready (emit[i]),
      .occupied   (occ[i]),
      .res_valid  (res_valid[i]),
      .res        (res[i])
    );
  end

  always_comb begin
    sel = '0;
    for (int i = 0; i < MAX_LOG2_SIZE; i++) begin
      if (res_valid[i]) begin
        sel = res[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (en) begin
      result_valid <= |res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result <= sel;
    end
  end

  a_one_token: assert property (@(posedge clk) disable iff (rst) $onehot0(occ))
    else $error("more than one transaction in the cell chain");

  a_one_result: assert property (@(posedge clk) disable iff (rst) $onehot0(res_valid))
    else $error("two cells produce a result in the same cycle");

  a_chain_end: assert property (@(posedge clk) disable iff (rst)
    !link_valid[MAX_LOG2_SIZE])
    else $error("transaction passed beyond the last level");

  a_not_last_pending: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.last) |-> (occ != '0))
    else $error("result not flagged last but no further level pending");

  a_cfg_clears: assert property (@(posedge clk) disable iff (rst)
    cfg_write |=> (log2_size != 4'd0) && (log2_size <= MAX_L))
    else $error("log2_size out of range after write");

endmodule
